>>> rtl/core/tone_list_sequencer_assert.svh
// ---------------------------------------------------------------------------
// Tone list sequencer assertion macros
// Wrappers for concurrent checks; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef TONE_LIST_SEQUENCER_ASSERT_SVH
`define TONE_LIST_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check on clk, masked while rst is high
`define TLS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tone list sequencer check failed");
// check on clk, also during reset
`define TLS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tone list sequencer check failed");
`else
`define TLS_ASSERT(label, prop)
`define TLS_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> rtl/core/tls_pkg.sv
// ---------------------------------------------------------------------------
// Tone list sequencer package
// Sizes, codes and shared types for the tone list sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package tls_pkg;

  localparam int LIST_DEPTH      = 7;
  localparam int TONE_COUNT      = 13;
  localparam int PROTECTED_SLOTS = 2;

  localparam int SLOT_W  = $clog2(TONE_COUNT + 1);
  localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int POS_W   = $clog2(LIST_DEPTH);
  localparam int MASK_W  = TONE_COUNT;
  localparam int CMD_W   = 3;
  localparam int CFG_IDX_W = 1;

  typedef logic [SLOT_W-1:0]               slot_t;
  typedef logic [LIST_DEPTH-1:0][SLOT_W-1:0] slot_row_t;
  typedef logic [CNT_W-1:0]                count_t;
  typedef logic [POS_W-1:0]                pos_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_MASK    = 3'd3,
    CMD_RESTART = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_FIRST  = 1'b0,
    CFG_BASE_SECOND = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_MASK = 1'b1
  } state_t;

  // row-wide control, same for every cell
  typedef struct packed {
    logic  add;      // append key at slot == count (already qualified)
    logic  remove;   // delete key if found outside protected slots
    logic  restart;  // load base tone values
    slot_t key;
  } ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/tls_cell.sv
// ---------------------------------------------------------------------------
// Tone list cell
// One list slot: matches the key, passes hit and shift flags down the row.
// ---------------------------------------------------------------------------
`default_nettype none

module tls_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tls_pkg::ctl_t ctl,
  input  wire logic          prot,
  input  wire logic          wr_sel,
  input  wire tls_pkg::slot_t restart_val,
  input  wire tls_pkg::slot_t right_val,
  input  wire logic          shift_in,
  input  wire logic          hit_in,
  output tls_pkg::slot_t     slot,
  output logic               shift_out,
  output logic               hit_out
);

  logic match;

  always_comb begin
    match     = (slot == ctl.key);
    shift_out = shift_in || (ctl.remove && match && !prot);
    hit_out   = hit_in || match;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (ctl.restart) begin
      slot <= restart_val;
    end else if (wr_sel) begin
      slot <= ctl.key;
    end else if (ctl.remove && shift_out) begin
      // this slot or one before it lost its tone: take the right neighbor
      slot <= right_val;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tls_chain.sv
// ---------------------------------------------------------------------------
// Tone list cell row
// Row of slot cells with ripple hit and shift flags.
// ---------------------------------------------------------------------------
`default_nettype none

module tls_chain (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tls_pkg::ctl_t     ctl,
  input  wire tls_pkg::count_t   count,
  input  wire tls_pkg::slot_row_t restart_vals,
  output tls_pkg::slot_row_t     slots,
  output logic                   present,
  output logic                   found
);

  logic [tls_pkg::LIST_DEPTH:0] shift;
  logic [tls_pkg::LIST_DEPTH:0] hit;

  assign shift[0] = 1'b0;
  assign hit[0]   = 1'b0;

  for (genvar j = 0; j < tls_pkg::LIST_DEPTH; j++) begin : g_cell
    tls_pkg::slot_t right_val;
    logic           wr_sel;

    if (j == tls_pkg::LIST_DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = slots[j+1];
    end

    assign wr_sel = ctl.add && (count == tls_pkg::CNT_W'(j));

    tls_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .prot        (j < tls_pkg::PROTECTED_SLOTS),
      .wr_sel      (wr_sel),
      .restart_val (restart_vals[j]),
      .right_val   (right_val),
      .shift_in    (shift[j]),
      .hit_in      (hit[j]),
      .slot        (slots[j]),
      .shift_out   (shift[j+1]),
      .hit_out     (hit[j+1])
    );
  end

  assign present = hit[tls_pkg::LIST_DEPTH];
  assign found   = shift[tls_pkg::LIST_DEPTH];

endmodule

`default_nettype wire

>>> rtl/core/tone_list_sequencer.sv
// ---------------------------------------------------------------------------
// Tone list sequencer
// Ordered transmit tone list with add, remove, band mask, tick and restart.
// ---------------------------------------------------------------------------
// Every request gives exactly one result. Tick, add, remove, restart and the
// unused codes finish in the cell row at the edge that accepts them. Their
// result enters the result buffer at that edge and moves to the output
// register at the next edge when the result side is free; the request side
// stalls while the buffer holds it. An apply-mask request walks tones 1..13
// through the cell row, one add or remove per cycle after its accept, and
// the request side stalls through the walk. Its result enters the result
// buffer with the last step and moves on to the output register the same
// way. The result buffer sits in front of the output register: one more
// request is taken and finished while a result waits on result_stall. The
// list itself is a row of seven slot cells; each compares the key, and hit
// and shift flags ripple from slot 0 up, so a remove closes the gap in the
// same cycle. Slots 0 and 1 are protected from remove. Config writes are
// always ready.
// ---------------------------------------------------------------------------
`default_nettype none

module tone_list_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request channel
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [tls_pkg::CMD_W-1:0]     command,
  input  wire logic [3:0]                    tone,
  input  wire logic [tls_pkg::MASK_W-1:0]    band_mask,
  // result channel
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [3:0]                         tx_tone,
  output logic [2:0]                         active_count,
  output logic                               list_changed,
  output logic                               rotation_wrapped,
  // config write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [3:0]                    cfg_data
);

  `include "tone_list_sequencer_assert.svh"

  // config registers
  tls_pkg::slot_t base_first;
  tls_pkg::slot_t base_second;

  // list state outside the cells
  tls_pkg::count_t count, count_next;
  tls_pkg::pos_t   pos, pos_next;

  // sequencer
  tls_pkg::state_t              state, state_next;
  logic [tls_pkg::MASK_W-1:0]   mask_sh, mask_sh_next;
  tls_pkg::slot_t               step, step_next;
  logic                         chg_acc, chg_acc_next;

  // finished result buffer
  logic            res_valid, res_valid_next;
  tls_pkg::slot_t  res_tx, res_tx_next;
  tls_pkg::count_t res_count, res_count_next;
  logic            res_chg, res_chg_next;
  logic            res_wrap, res_wrap_next;

  // row interface
  tls_pkg::ctl_t      ctl;
  tls_pkg::slot_row_t slots;
  tls_pkg::slot_row_t restart_vals;
  tls_pkg::count_t    restart_count;
  logic               present;
  logic               found;

  logic           accept;
  logic           out_load;
  logic           do_add;
  logic           do_rem;
  logic           key_ok;
  logic           add_ok;
  logic           b1_ok;
  logic           b2_ok;
  tls_pkg::pos_t  pick;
  tls_pkg::count_t adv;
  logic           tail_clean;
  logic           tick_acc;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != tls_pkg::ST_IDLE) || res_valid;
  assign accept     = item_valid && !item_stall;
  assign out_load   = res_valid && (!result_valid || !result_stall);

  tls_chain u_chain (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .count        (count),
    .restart_vals (restart_vals),
    .slots        (slots),
    .present      (present),
    .found        (found)
  );

  // restart image: valid base tones packed from slot 0
  always_comb begin
    b1_ok = (base_first != '0) && (base_first <= tls_pkg::SLOT_W'(tls_pkg::TONE_COUNT));
    b2_ok = (base_second != '0) &&
            (base_second <= tls_pkg::SLOT_W'(tls_pkg::TONE_COUNT)) &&
            (base_second != base_first);
    restart_vals    = '0;
    restart_vals[0] = b1_ok ? base_first : (b2_ok ? base_second : '0);
    restart_vals[1] = (b1_ok && b2_ok) ? base_second : '0;
    restart_count   = tls_pkg::CNT_W'(b1_ok) + tls_pkg::CNT_W'(b2_ok);
  end

  // sequencer and datapath
  always_comb begin
    state_next     = state;
    count_next     = count;
    pos_next       = pos;
    mask_sh_next   = mask_sh;
    step_next      = step;
    chg_acc_next   = chg_acc;
    res_valid_next = res_valid && !out_load;
    res_tx_next    = res_tx;
    res_count_next = res_count;
    res_chg_next   = res_chg;
    res_wrap_next  = res_wrap;
    do_add         = 1'b0;
    do_rem         = 1'b0;
    ctl            = '0;
    ctl.key        = (state == tls_pkg::ST_MASK) ? step : tone;
    pick           = '0;
    adv            = '0;

    key_ok = (ctl.key != '0) && (ctl.key <= tls_pkg::SLOT_W'(tls_pkg::TONE_COUNT));

    unique case (state)
      tls_pkg::ST_IDLE: begin
        if (accept) begin
          res_valid_next = 1'b1;
          res_tx_next    = '0;
          res_chg_next   = 1'b0;
          res_wrap_next  = 1'b0;
          unique case (command)
            tls_pkg::CMD_TICK: begin
              if (count == '0) begin
                pos_next = '0;
              end else begin
                // stale position restarts from slot 0
                pick = (tls_pkg::CNT_W'(pos) >= count) ? '0 : pos;
                res_tx_next = slots[pick];
                adv = tls_pkg::CNT_W'(pick) + tls_pkg::CNT_W'(1);
                if (adv >= count) begin
                  pos_next      = '0;
                  res_wrap_next = 1'b1;
                end else begin
                  pos_next = tls_pkg::POS_W'(adv);
                end
              end
            end
            tls_pkg::CMD_ADD:     do_add = 1'b1;
            tls_pkg::CMD_REMOVE:  do_rem = 1'b1;
            tls_pkg::CMD_MASK: begin
              res_valid_next = 1'b0;
              state_next     = tls_pkg::ST_MASK;
              mask_sh_next   = band_mask;
              step_next      = tls_pkg::SLOT_W'(1);
              chg_acc_next   = 1'b0;
            end
            tls_pkg::CMD_RESTART: begin
              ctl.restart  = 1'b1;
              count_next   = restart_count;
              pos_next     = '0;
              res_chg_next = (restart_vals != slots) || (restart_count != count);
            end
            default: ;
          endcase
        end
      end
      tls_pkg::ST_MASK: begin
        do_add       = mask_sh[0];
        do_rem       = !mask_sh[0];
        mask_sh_next = mask_sh >> 1;
        step_next    = step + tls_pkg::SLOT_W'(1);
      end
      default: ;
    endcase

    add_ok     = do_add && key_ok && (count < tls_pkg::CNT_W'(tls_pkg::LIST_DEPTH)) &&
                 !present;
    ctl.add    = add_ok;
    ctl.remove = do_rem && key_ok;

    if (add_ok) begin
      count_next = count + tls_pkg::CNT_W'(1);
    end else if (ctl.remove && found) begin
      count_next = count - tls_pkg::CNT_W'(1);
    end

    if (state == tls_pkg::ST_IDLE) begin
      if (accept && (command == tls_pkg::CMD_ADD || command == tls_pkg::CMD_REMOVE)) begin
        res_chg_next = add_ok || (ctl.remove && found);
      end
      if (accept) begin
        res_count_next = count_next;
      end
    end else begin
      chg_acc_next = chg_acc || add_ok || (ctl.remove && found);
      if (step == tls_pkg::SLOT_W'(tls_pkg::TONE_COUNT)) begin
        state_next     = tls_pkg::ST_IDLE;
        res_valid_next = 1'b1;
        res_tx_next    = '0;
        res_count_next = count_next;
        res_chg_next   = chg_acc_next;
        res_wrap_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tls_pkg::ST_IDLE;
      count      <= '0;
      pos        <= '0;
      res_valid  <= 1'b0;
      base_first <= tls_pkg::SLOT_W'(1);
      base_second <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pos       <= pos_next;
      res_valid <= res_valid_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tls_pkg::CFG_BASE_FIRST:  base_first  <= cfg_data;
          tls_pkg::CFG_BASE_SECOND: base_second <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    mask_sh   <= mask_sh_next;
    step      <= step_next;
    chg_acc   <= chg_acc_next;
    res_tx    <= res_tx_next;
    res_count <= res_count_next;
    res_chg   <= res_chg_next;
    res_wrap  <= res_wrap_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      tx_tone          <= res_tx;
      active_count     <= res_count;
      list_changed     <= res_chg;
      rotation_wrapped <= res_wrap;
    end
  end

  // slots at or past the count must read as empty
  always_comb begin
    tail_clean = 1'b1;
    for (int j = 0; j < tls_pkg::LIST_DEPTH; j++) begin
      if ((tls_pkg::CNT_W'(j) >= count) && (slots[j] != '0)) begin
        tail_clean = 1'b0;
      end
    end
  end

  assign tick_acc = accept && (command == tls_pkg::CMD_TICK);

  `TLS_ASSERT(a_busy_after_accept, accept |=> item_stall)
  `TLS_ASSERT(a_tail_clean, tail_clean && (count <= tls_pkg::CNT_W'(tls_pkg::LIST_DEPTH)))
  `TLS_ASSERT(a_tick_pos, tick_acc |=> ((tls_pkg::CNT_W'(pos) < count) || (pos == '0)))
  `TLS_ASSERT_ALWAYS(a_reset_idle, rst |=> (!result_valid && !res_valid))

endmodule

`default_nettype wire
